### design/fvom_pkg.sv
// Shared types, register codes and the quarter-wave sine table for the
// four-voice oscillator mixer. No dependencies.
`default_nettype none

package fvom_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SQUARE_STEP   = 3'd0;
  localparam logic [2:0] REG_SAW_STEP      = 3'd1;
  localparam logic [2:0] REG_SINE_STEP     = 3'd2;
  localparam logic [2:0] REG_SQUARE_VOLUME = 3'd3;
  localparam logic [2:0] REG_SAW_VOLUME    = 3'd4;
  localparam logic [2:0] REG_SINE_VOLUME   = 3'd5;
  localparam logic [2:0] REG_NOISE_VOLUME  = 3'd6;

  // Accumulate source select
  localparam logic [1:0] ACC_SAW   = 2'd0;
  localparam logic [1:0] ACC_SINE  = 2'd1;
  localparam logic [1:0] ACC_NOISE = 2'd2;

  // Restoring remainder runs one bit per cycle over the random byte
  localparam int unsigned MOD_STEPS = 8;

  localparam int unsigned QUARTER_TABLE_DEPTH = 64;

  // q[t] = 128 + round(127 * sin(t * pi / 128))
  localparam logic [7:0] QUARTER_SINE [QUARTER_TABLE_DEPTH] = '{
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd144, 8'd147, 8'd150,
    8'd153, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
    8'd177, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193, 8'd196,
    8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd216,
    8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd234, 8'd235, 8'd237, 8'd239, 8'd240, 8'd241, 8'd243, 8'd244,
    8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
    8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255
  };

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] square_step;
    logic [15:0] saw_step;
    logic [15:0] sine_step;
    logic [7:0]  square_volume;
    logic [7:0]  saw_volume;
    logic [7:0]  sine_volume;
    logic [7:0]  noise_volume;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       start;     // latch random byte, arm remainder unit
    logic       phase_en;  // advance phases, seed sum with square voice
    logic       mul_en;    // load product register
    logic       mul_sine;  // 1: sine operands, 0: saw operands
    logic       acc_en;    // add one voice to the sum
    logic [1:0] acc_sel;
    logic       mod_step;  // one remainder iteration
    logic       load_out;  // clamp sum into the output word
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } stat_t;

  // Full-wave sine of the phase high byte, folded from the quarter table
  function automatic logic [7:0] sine_of(input logic [7:0] h);
    logic [5:0] idx;
    logic [7:0] q;
    idx = h[6] ? ~h[5:0] : h[5:0];
    q   = QUARTER_SINE[idx];
    return h[7] ? ~q : q;
  endfunction

endpackage

`default_nettype wire

### design/four_voice_oscillator_mixer_unit.sv
// Four-voice oscillator mixer: square, sawtooth and sine DDS voices plus a
// noise voice, summed into one clamped unsigned 8-bit sample per tick word.
// Each accepted tick runs through the whole sequence before the next tick is
// accepted; it is set by one shared 8x8 multiplier used twice (saw, sine) and
// a one-bit-per-cycle remainder unit for the noise voice. The finished sample
// sits in an output register, so a new tick is taken while it waits. Registers
// are written through the cfg port (always ready) by the user only while idle;
// the block does not enforce it. Depends on fvom_pkg, fvom_ctrl, fvom_dp.
`default_nettype none

module four_voice_oscillator_mixer_unit import fvom_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  // tick words
  input  wire        tick_valid,
  output logic       tick_stall,
  input  wire [7:0]  random_byte,
  // sample words
  output logic       sample_valid,
  input  wire        sample_stall,
  output logic [7:0] pcm_sample,
  // register writes
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [2:0]  cfg_index,
  input  wire [15:0] cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  assign cfg_ready  = 1'b1;
  assign tick_stall = busy;

  // Register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SQUARE_STEP:   cfg.square_step   <= cfg_data;
        REG_SAW_STEP:      cfg.saw_step      <= cfg_data;
        REG_SINE_STEP:     cfg.sine_step     <= cfg_data;
        REG_SQUARE_VOLUME: cfg.square_volume <= cfg_data[7:0];
        REG_SAW_VOLUME:    cfg.saw_volume    <= cfg_data[7:0];
        REG_SINE_VOLUME:   cfg.sine_volume   <= cfg_data[7:0];
        REG_NOISE_VOLUME:  cfg.noise_volume  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  fvom_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .busy       (busy),
    .stat       (stat),
    .cmd        (cmd)
  );

  fvom_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .random_byte  (random_byte),
    .stat         (stat),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .pcm_sample   (pcm_sample)
  );

endmodule

`default_nettype wire

### design/fvom_ctrl.sv
// Sequencing controller for the oscillator mixer: walks each tick word
// through phase update, two multiplies, the remainder loop and output load.
// Depends on fvom_pkg.
`default_nettype none

module fvom_ctrl import fvom_pkg::*; (
  input  wire   clk,
  input  wire   rst,
  input  wire   tick_valid,
  output logic  busy,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PHASE     = 4'd1;
  localparam logic [3:0] S_SAW_MUL   = 4'd2;
  localparam logic [3:0] S_SAW_ACC   = 4'd3;
  localparam logic [3:0] S_SINE_MUL  = 4'd4;
  localparam logic [3:0] S_SINE_ACC  = 4'd5;
  localparam logic [3:0] S_MOD       = 4'd6;
  localparam logic [3:0] S_NOISE_ACC = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;

  localparam logic [2:0] MOD_LAST = 3'(MOD_STEPS - 1);

  logic [3:0] state, state_next;
  logic [2:0] mod_cnt, mod_cnt_next;

  // State and remainder iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mod_cnt <= '0;
    end else begin
      state   <= state_next;
      mod_cnt <= mod_cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next   = state;
    mod_cnt_next = mod_cnt;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (tick_valid) begin
          cmd.start  = 1'b1;
          state_next = S_PHASE;
        end
      end
      S_PHASE: begin
        cmd.phase_en = 1'b1;
        state_next   = S_SAW_MUL;
      end
      S_SAW_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_SAW_ACC;
      end
      S_SAW_ACC: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = ACC_SAW;
        state_next  = S_SINE_MUL;
      end
      S_SINE_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sine = 1'b1;
        state_next   = S_SINE_ACC;
      end
      S_SINE_ACC: begin
        cmd.acc_en   = 1'b1;
        cmd.acc_sel  = ACC_SINE;
        mod_cnt_next = '0;
        state_next   = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        mod_cnt_next = mod_cnt + 3'd1;
        if (mod_cnt == MOD_LAST) begin
          state_next = S_NOISE_ACC;
        end
      end
      S_NOISE_ACC: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = ACC_NOISE;
        state_next  = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the word
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/fvom_dp.sv
// Datapath for the oscillator mixer: phase accumulators, shared 8x8
// multiplier, bit-serial remainder unit, sum and output register.
// Depends on fvom_pkg.
`default_nettype none

module fvom_dp import fvom_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  cfg_t       cfg,
  input  cmd_t       cmd,
  input  wire [7:0]  random_byte,
  output stat_t      stat,
  output logic       sample_valid,
  input  wire        sample_stall,
  output logic [7:0] pcm_sample
);

  logic [15:0] square_phase, saw_phase, sine_phase;
  logic [15:0] square_phase_next;
  logic [15:0] product;
  logic [7:0]  mod_rem, mod_div;
  logic signed [10:0] sum;

  logic [7:0]  mul_a, mul_b;
  logic [8:0]  mod_trial;
  logic [7:0]  acc_vol;
  logic [7:0]  acc_val;
  logic [10:0] acc_term;
  logic [10:0] square_term;
  logic [6:0]  square_half;

  // Phase accumulators; a silent voice holds its phase
  assign square_phase_next = square_phase + cfg.square_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_phase <= '0;
      saw_phase    <= '0;
      sine_phase   <= '0;
    end else if (cmd.phase_en) begin
      if (cfg.square_volume != 8'd0) square_phase <= square_phase_next;
      if (cfg.saw_volume != 8'd0)    saw_phase    <= saw_phase + cfg.saw_step;
      if (cfg.sine_volume != 8'd0)   sine_phase   <= sine_phase + cfg.sine_step;
    end
  end

  // Shared multiplier, registered product
  assign mul_a = cmd.mul_sine ? sine_of(sine_phase[15:8]) : saw_phase[15:8];
  assign mul_b = cmd.mul_sine ? cfg.sine_volume : cfg.saw_volume;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      product <= mul_a * mul_b;
    end
  end

  // Restoring remainder of the random byte by the noise volume
  assign mod_trial = {mod_rem, mod_div[7]};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mod_rem <= '0;
      mod_div <= random_byte;
    end else if (cmd.mod_step) begin
      mod_div <= {mod_div[6:0], 1'b0};
      if (mod_trial >= {1'b0, cfg.noise_volume}) begin
        mod_rem <= 8'(mod_trial - {1'b0, cfg.noise_volume});
      end else begin
        mod_rem <= mod_trial[7:0];
      end
    end
  end

  // Square voice term, seeded with the 255 output offset
  assign square_half = cfg.square_volume[7:1];
  always_comb begin
    if (cfg.square_volume == 8'd0) begin
      square_term = 11'd255;
    end else if (square_phase_next[15]) begin
      square_term = 11'd255 + {4'd0, square_half};
    end else begin
      square_term = 11'd255 - {4'd0, square_half};
    end
  end

  // Term for the other voices
  always_comb begin
    case (cmd.acc_sel)
      ACC_SAW: begin
        acc_vol = cfg.saw_volume;
        acc_val = product[15:8];
      end
      ACC_SINE: begin
        acc_vol = cfg.sine_volume;
        acc_val = product[15:8];
      end
      ACC_NOISE: begin
        acc_vol = cfg.noise_volume;
        acc_val = mod_rem;
      end
      default: begin
        acc_vol = '0;
        acc_val = '0;
      end
    endcase
    if (acc_vol == 8'd0) begin
      acc_term = '0;
    end else begin
      acc_term = {3'd0, acc_val} - {4'd0, acc_vol[7:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.phase_en) begin
      sum <= $signed(square_term);
    end else if (cmd.acc_en) begin
      sum <= sum + $signed(acc_term);
    end
  end

  // Output register with clamp
  assign stat.out_free = !sample_valid || !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (cmd.load_out) begin
      sample_valid <= 1'b1;
    end else if (!sample_stall) begin
      sample_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (sum < 0) begin
        pcm_sample <= 8'd0;
      end else if (sum > 11'sd255) begin
        pcm_sample <= 8'd255;
      end else begin
        pcm_sample <= sum[7:0];
      end
    end
  end

endmodule

`default_nettype wire

### dv/four_voice_oscillator_mixer_unit_tb.sv
// Self-checking testbench for four_voice_oscillator_mixer_unit: tick words in,
// mixed pcm sample words out, register writes between phases.
// Depends on fvom_pkg and the RTL of the mixer unit.
`timescale 1ns / 1ps

module four_voice_oscillator_mixer_unit_tb;
  import fvom_pkg::*;

  // Write to an index past the register list, dropped by the block
  localparam logic [2:0] REG_BEYOND = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 55;
  localparam int LONG_HOLD = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  index;
    logic [15:0] data;
    logic [7:0]  rnd;
    logic        known;
    logic [7:0]  sample;
  } plan_row_t;

  localparam int PLAN_ROWS = 31;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // all voices silent after reset: output at the top of the range
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'h00, 1'b1, 8'd255},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'hFF, 1'b1, 8'd255},
    // noise alone at full volume
    '{ROW_WRITE, REG_NOISE_VOLUME,  16'h00FF, 8'h00, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'hFF, 1'b1, 8'd128},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'hFE, 1'b1, 8'd255},
    // every voice at full volume, phases at zero: clamps low
    '{ROW_WRITE, REG_SQUARE_VOLUME, 16'hFFFF, 8'h00, 1'b0, 8'd0},
    '{ROW_WRITE, REG_SAW_VOLUME,    16'h00FF, 8'h00, 1'b0, 8'd0},
    '{ROW_WRITE, REG_SINE_VOLUME,   16'h00FF, 8'h00, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'h00, 1'b1, 8'd0},
    // steps that walk through the square halves and sine quadrants
    '{ROW_WRITE, REG_SQUARE_STEP,   16'h8000, 8'h00, 1'b0, 8'd0},
    '{ROW_WRITE, REG_SAW_STEP,      16'hFFFF, 8'h00, 1'b0, 8'd0},
    '{ROW_WRITE, REG_SINE_STEP,     16'h4000, 8'h00, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'h80, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'h7F, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'h55, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'hAA, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'h01, 1'b0, 8'd0},
    // noise modulus of one; a write past the list changes nothing
    '{ROW_WRITE, REG_NOISE_VOLUME,  16'h0001, 8'h00, 1'b0, 8'd0},
    '{ROW_WRITE, REG_BEYOND,        16'hFFFF, 8'h00, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'h3C, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'hC3, 1'b0, 8'd0},
    // zero noise volume: no remainder taken
    '{ROW_WRITE, REG_NOISE_VOLUME,  16'h0000, 8'h00, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'hFF, 1'b0, 8'd0},
    // square frozen, finer sine step
    '{ROW_WRITE, REG_SQUARE_VOLUME, 16'h0000, 8'h00, 1'b0, 8'd0},
    '{ROW_WRITE, REG_SINE_STEP,     16'h0100, 8'h00, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'h10, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'hEF, 1'b0, 8'd0},
    // smallest saw volume, half sine volume
    '{ROW_WRITE, REG_SAW_VOLUME,    16'h0001, 8'h00, 1'b0, 8'd0},
    '{ROW_WRITE, REG_SINE_VOLUME,   16'h0080, 8'h00, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'h5A, 1'b0, 8'd0},
    '{ROW_TICK,  REG_BEYOND,        16'h0000, 8'hA5, 1'b0, 8'd0}
  };

  // q[t] = 128 + round(127 sin(t pi / 128)), first quarter of the wave
  localparam int SINE_QUARTER [64] = '{
    128, 131, 134, 137, 140, 144, 147, 150,
    153, 156, 159, 162, 165, 168, 171, 174,
    177, 179, 182, 185, 188, 191, 193, 196,
    199, 201, 204, 206, 209, 211, 213, 216,
    218, 220, 222, 224, 226, 228, 230, 232,
    234, 235, 237, 239, 240, 241, 243, 244,
    245, 246, 248, 249, 250, 250, 251, 252,
    253, 253, 254, 254, 254, 255, 255, 255
  };

  logic        clk;
  logic        rst;
  logic        tick_valid;
  logic        tick_stall;
  logic [7:0]  random_byte;
  logic        sample_valid;
  logic        sample_stall;
  logic [7:0]  pcm_sample;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  four_voice_oscillator_mixer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .random_byte  (random_byte),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .pcm_sample   (pcm_sample),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Mixer shadow state
  cfg_t        shadow_cfg;
  logic [15:0] square_acc, saw_acc, sine_acc;

  logic [7:0]  pending_samples [$];
  logic [7:0]  want_sample;
  int          mismatch_count;
  int          sample_count;
  int          idle_cycles;
  bit          bursts_on;
  int          long_hold_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH: %s", what);
    mismatch_count++;
  endtask

  function automatic int sine_level(input int h);
    if (h < 64) return SINE_QUARTER[h];
    if (h < 128) return SINE_QUARTER[127 - h];
    if (h < 192) return 255 - SINE_QUARTER[h - 128];
    return 255 - SINE_QUARTER[255 - h];
  endfunction

  // One audio tick: advance live voices, sum, offset and clamp
  function automatic logic [7:0] mix_tick(input logic [7:0] rnd);
    int mix, vol;
    mix = 0;
    vol = shadow_cfg.square_volume;
    if (vol != 0) begin
      square_acc = square_acc + shadow_cfg.square_step;
      mix = square_acc[15] ? mix + (vol >> 1) : mix - (vol >> 1);
    end
    vol = shadow_cfg.saw_volume;
    if (vol != 0) begin
      saw_acc = saw_acc + shadow_cfg.saw_step;
      mix = mix + ((vol * int'(saw_acc[15:8])) >> 8) - (vol >> 1);
    end
    vol = shadow_cfg.sine_volume;
    if (vol != 0) begin
      sine_acc = sine_acc + shadow_cfg.sine_step;
      mix = mix + ((sine_level(int'(sine_acc[15:8])) * vol) >> 8) - (vol >> 1);
    end
    vol = shadow_cfg.noise_volume;
    if (vol != 0)
      mix = mix + (int'(rnd) % vol) - (vol >> 1);
    mix = mix + 255;
    if (mix > 255) mix = 255;
    else if (mix < 0) mix = 0;
    return mix[7:0];
  endfunction

  function automatic void apply_reg(input logic [2:0] index, input logic [15:0] data);
    case (index)
      REG_SQUARE_STEP:   shadow_cfg.square_step   = data;
      REG_SAW_STEP:      shadow_cfg.saw_step      = data;
      REG_SINE_STEP:     shadow_cfg.sine_step     = data;
      REG_SQUARE_VOLUME: shadow_cfg.square_volume = data[7:0];
      REG_SAW_VOLUME:    shadow_cfg.saw_volume    = data[7:0];
      REG_SINE_VOLUME:   shadow_cfg.sine_volume   = data[7:0];
      REG_NOISE_VOLUME:  shadow_cfg.noise_volume  = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      3: return 16'h00FF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one tick word; valid stays high into the next call unless a gap falls
  task automatic send_tick(input logic [7:0] rnd, input logic known,
                           input logic [7:0] typed);
    logic [7:0] predicted;
    @(negedge clk);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      tick_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    tick_valid  = 1'b1;
    random_byte = rnd;
    do @(posedge clk); while (tick_stall);
    predicted = mix_tick(rnd);
    pending_samples.push_back(known ? typed : predicted);
  endtask

  task automatic end_ticks();
    @(negedge clk);
    tick_valid = 1'b0;
  endtask

  task automatic drain_samples();
    end_ticks();
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sample receiver: random stall bursts, or one long hold on request
  initial begin
    sample_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_cycles != 0) begin
        sample_stall = 1'b1;
        repeat (long_hold_cycles) @(negedge clk);
        long_hold_cycles = 0;
        sample_stall = 1'b0;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        sample_stall = 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        sample_stall = 1'b0;
      end
    end
  end

  // Compare each accepted sample word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d: word %0d with none expected",
                                  sample_count, pcm_sample));
      end else begin
        want_sample = pending_samples.pop_front();
        if (pcm_sample !== want_sample)
          report_mismatch($sformatf("sample %0d: pcm_sample %0d, expected %0d",
                                    sample_count, pcm_sample, want_sample));
      end
      sample_count++;
    end
  end

  // Watchdog on cycles with no word moved on any channel
  always @(posedge clk) begin
    if (rst || (tick_valid && !tick_stall) || (sample_valid && !sample_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", idle_cycles);
        $display("four_voice_oscillator_mixer_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    tick_valid = 1'b0;
    random_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_SQUARE_STEP;
    cfg_data = 16'h0000;
    shadow_cfg = '0;
    square_acc = '0;
    saw_acc = '0;
    sine_acc = '0;
    mismatch_count = 0;
    sample_count = 0;
    idle_cycles = 0;
    bursts_on = 1'b1;
    long_hold_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int row = 0; row < PLAN_ROWS; row++) begin
      if (DIRECTED_PLAN[row].kind == ROW_WRITE) begin
        drain_samples();
        write_reg(DIRECTED_PLAN[row].index, DIRECTED_PLAN[row].data);
      end else begin
        send_tick(DIRECTED_PLAN[row].rnd, DIRECTED_PLAN[row].known,
                  DIRECTED_PLAN[row].sample);
      end
    end
    drain_samples();

    // Random phases: fresh settings, then a run of ticks
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      bursts_on = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int r = REG_SQUARE_STEP; r <= REG_NOISE_VOLUME; r++)
        write_reg(3'(r), pick_word());
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_BEYOND, 16'($urandom));
      if (phase == 3)
        long_hold_cycles = LONG_HOLD;
      for (int n = 0; n < TICKS_PER_PHASE; n++)
        send_tick(8'($urandom_range(0, 255)), 1'b0, 8'h00);
      drain_samples();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("four_voice_oscillator_mixer_unit verification clean");
    else
      $display("four_voice_oscillator_mixer_unit verification failed");
    $finish;
  end

endmodule

### four_voice_oscillator_mixer_unit.f
design/fvom_pkg.sv
design/fvom_ctrl.sv
design/fvom_dp.sv
design/four_voice_oscillator_mixer_unit.sv
dv/four_voice_oscillator_mixer_unit_tb.sv
